/* sv/sjut_pkg.sv */
// Shared types, constants and helpers for the Shift-JIS / UTF-8 text detector.
package sjut_pkg;

    localparam int MAX_LEN = 4096;
    localparam int SCORE_W = $clog2(MAX_LEN + 1);
    localparam int OUT_W   = 1 + 1 + 2 * SCORE_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [7:0] BOM_0 = 8'hEF;
    localparam logic [7:0] BOM_1 = 8'hBB;
    localparam logic [7:0] BOM_2 = 8'hBF;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_LATER  = 2'd3;

    typedef struct packed {
        logic               sjis_skip;
        logic [1:0]         utf8_skip;
        logic [SCORE_W-1:0] sjis_total;
        logic [SCORE_W-1:0] utf8_total;
    } scan_state_t;

    function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] total,
                                                   input logic [1:0]         inc);
        logic [SCORE_W:0] sum;
        sum = {1'b0, total} + {{(SCORE_W - 1){1'b0}}, inc};
        if (sum > (SCORE_W + 1)'(MAX_LEN))
            return SCORE_W'(MAX_LEN);
        return sum[SCORE_W-1:0];
    endfunction

endpackage

/* sv/sjut_scan.sv */
// Pair scanners: one window position for the Shift-JIS and UTF-8 scores.
module sjut_scan
    import sjut_pkg::*;
(
    input  logic        scan_en,
    input  logic [7:0]  b1,
    input  logic [7:0]  b2,
    input  logic [7:0]  b3,
    input  scan_state_t cur,
    output scan_state_t nxt
);

    logic sjis_lead;
    logic sjis_trail;
    logic utf8_lead2;
    logic utf8_lead3;
    logic cont2;
    logic cont3;

    always_comb
    begin
        sjis_lead  = b1 inside {[8'h81:8'h9F], [8'hE0:8'hFC]};
        sjis_trail = b2 inside {[8'h40:8'h7E], [8'h80:8'hFC]};
        utf8_lead2 = b1 inside {[8'hC0:8'hDF]};
        utf8_lead3 = b1 inside {[8'hE0:8'hEF]};
        cont2      = b2 inside {[8'h80:8'hBF]};
        cont3      = b3 inside {[8'h80:8'hBF]};
    end

    always_comb
    begin
        nxt = cur;
        if (scan_en)
        begin
            if (cur.sjis_skip)
            begin
                nxt.sjis_skip = 1'b0;
            end
            else if (sjis_lead && sjis_trail)
            begin
                nxt.sjis_total = sat_add(cur.sjis_total, 2'd2);
                nxt.sjis_skip  = 1'b1;
            end

            if (cur.utf8_skip != 2'd0)
            begin
                nxt.utf8_skip = cur.utf8_skip - 2'd1;
            end
            else if (utf8_lead2 && cont2)
            begin
                nxt.utf8_total = sat_add(cur.utf8_total, 2'd2);
                nxt.utf8_skip  = 2'd1;
            end
            else if (utf8_lead3 && cont2 && cont3)
            begin
                nxt.utf8_total = sat_add(cur.utf8_total, 2'd3);
                nxt.utf8_skip  = 2'd2;
            end
        end
    end

endmodule

/* sv/sjis_utf8_text_detector.sv */
// Top level of the Shift-JIS versus UTF-8 text detector.
//
// Usage: feed the bytes of one text on the s_axis channel, one byte per
// request, with s_axis_tlast high on the final byte. On that final byte the
// block emits one verdict on m_axis: is_utf8, bom_found and both pair scores.
// No result is emitted for the other bytes; a new text starts right after.
// Datapath: a byte is registered at the input, then scored into the state and
// result registers; the result register drives m_axis. Throughput is one
// byte per cycle unless a held verdict stalls a final byte; the per-byte
// update is a single pass through the window compare and score adder.
// The output register holds a verdict while m_axis_tready is low; input
// bytes keep flowing until a second final byte would need that register, at
// which point s_axis_tready drops until the verdict is taken.
// Reset clears all scores, the window, the mark tracking and both valid
// flags; the block is ready for the first byte of a new text.
module sjis_utf8_text_detector
    import sjut_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] byte_value
    input  logic                   s_axis_tlast,   // last_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] is_utf8, [1] bom_found, [SCORE_W+1:2] sjis_score,
    // [2*SCORE_W+1:SCORE_W+2] utf8_score, zero padded above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    logic               step;

    logic [7:0]         win0_reg, win0_next;
    logic [7:0]         win1_reg, win1_next;
    logic [1:0]         pos_reg, pos_next;
    logic               bom_partial_reg, bom_partial_next;
    scan_state_t        scan_reg, scan_next, scan_upd;

    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    logic               scan_en;
    logic               bom_ok;
    logic               bom;
    logic               verdict;

    // Advance the scoring stage unless a verdict would overwrite a held one.
    assign step          = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    assign scan_en = (pos_reg == POS_THIRD) || (pos_reg == POS_LATER);

    sjut_scan u_scan (
        .scan_en (scan_en),
        .b1      (win0_reg),
        .b2      (win1_reg),
        .b3      (in_byte_reg),
        .cur     (scan_reg),
        .nxt     (scan_upd)
    );

    always_comb
    begin
        case (pos_reg)
            POS_FIRST:  bom_ok = (in_byte_reg == BOM_0);
            POS_SECOND: bom_ok = (in_byte_reg == BOM_1);
            POS_THIRD:  bom_ok = (in_byte_reg == BOM_2);
            default:    bom_ok = 1'b1;
        endcase
    end

    always_comb
    begin
        bom     = bom_partial_reg && bom_ok && scan_en;
        verdict = bom || ((pos_reg != POS_FIRST) && (scan_upd.utf8_total > scan_upd.sjis_total));
        out_data_next = {scan_upd.utf8_total, scan_upd.sjis_total, bom, verdict};

        win0_next        = win0_reg;
        win1_next        = win1_reg;
        pos_next         = pos_reg;
        bom_partial_next = bom_partial_reg;
        scan_next        = scan_reg;
        if (step)
        begin
            if (in_last_reg)
            begin
                // Clear for the next text.
                win0_next        = 8'h00;
                win1_next        = 8'h00;
                pos_next         = POS_FIRST;
                bom_partial_next = 1'b1;
                scan_next        = '0;
            end
            else
            begin
                win0_next        = win1_reg;
                win1_next        = in_byte_reg;
                pos_next         = (pos_reg == POS_LATER) ? POS_LATER : pos_reg + 2'd1;
                bom_partial_next = bom_partial_reg && bom_ok;
                scan_next        = scan_upd;
            end
        end

        out_valid_next = out_valid_reg && !m_axis_tready;
        if (step && in_last_reg)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg        <= 8'h00;
            win1_reg        <= 8'h00;
            pos_reg         <= POS_FIRST;
            bom_partial_reg <= 1'b1;
            scan_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            win0_reg        <= win0_next;
            win1_reg        <= win1_next;
            pos_reg         <= pos_next;
            bom_partial_reg <= bom_partial_next;
            scan_reg        <= scan_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_data_reg};

    // A mark always forces the UTF-8 verdict.
    a_bom_implies_utf8: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[0]))
        else $error("bom_found without is_utf8");

    // Scores never pass the saturation limit.
    a_score_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_reg.sjis_total <= SCORE_W'(MAX_LEN)) && (scan_reg.utf8_total <= SCORE_W'(MAX_LEN)))
        else $error("score above saturation limit");

    // A final byte leaves the scanners cleared for the next text.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_last_reg) |=>
            (pos_reg == POS_FIRST) && (scan_reg == '0) && bom_partial_reg)
        else $error("state not cleared after final byte");

    // A held verdict blocks the next final byte from being scored.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready && in_valid_reg && in_last_reg) |-> !step)
        else $error("held verdict overwritten");

endmodule

/* tb/testbench.sv */
// Self-checking bench for the Shift-JIS / UTF-8 text detector: directed and random texts.
module testbench;
    import sjut_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_BYTES = 400;

    typedef struct packed {
        logic [SCORE_W-1:0] utf8_score;
        logic [SCORE_W-1:0] sjis_score;
        logic               bom_found;
        logic               is_utf8;
    } verdict_t;

    typedef struct {
        logic [7:0] value;
        bit         is_last;
        bit         typed;
        verdict_t   want;
    } text_row_t;

    typedef enum int {
        TXT_ASCII,
        TXT_UTF8,
        TXT_SJIS,
        TXT_MARKED,
        TXT_MIXED,
        TXT_NOISE
    } text_style_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // detector state mirrored from the block's behavior
    logic [7:0] win_b1;
    logic [7:0] win_b2;
    logic [1:0] seen_count;
    bit         mark_intact;
    bit         sj_skip;
    logic [1:0] u8_skip;
    int         sj_score;
    int         u8_score;

    verdict_t   verdicts_due[$];
    text_row_t  dir_rows[$];
    logic [7:0] text_buf[$];

    bit steady;
    int mismatches;
    int bytes_sent;
    int texts_sent;
    int verdicts_checked;
    int utf8_verdicts;
    int marked_verdicts;

    sjis_utf8_text_detector dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] byte_value
        .s_axis_tlast  (s_axis_tlast),   // last_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [0] is_utf8, [1] bom_found, [14:2] sjis_score, [27:15] utf8_score
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit in_span(input logic [7:0] v, input logic [7:0] lo,
                                   input logic [7:0] hi);
        return v >= lo && v <= hi;
    endfunction

    function automatic int add_capped(input int total, input int inc);
        return (total + inc > MAX_LEN) ? MAX_LEN : total + inc;
    endfunction

    function automatic void clear_scan_state();
        win_b1      = 8'h00;
        win_b2      = 8'h00;
        seen_count  = POS_FIRST;
        mark_intact = 1'b1;
        sj_skip     = 1'b0;
        u8_skip     = 2'd0;
        sj_score    = 0;
        u8_score    = 0;
    endfunction

    // Advance the detector by one byte; return 1 and the verdict on the final byte.
    function automatic bit classify_byte(input logic [7:0] b, input bit is_last,
                                         output verdict_t v);
        logic [1:0] k;
        bit         marked;
        k = seen_count;
        v = '0;
        if (k == POS_FIRST && b != BOM_0)
            mark_intact = 1'b0;
        if (k == POS_SECOND && b != BOM_1)
            mark_intact = 1'b0;
        if (k == POS_THIRD && b != BOM_2)
            mark_intact = 1'b0;

        if (k >= POS_THIRD)
        begin
            if (sj_skip)
                sj_skip = 1'b0;
            else if ((in_span(win_b1, 8'h81, 8'h9F) || in_span(win_b1, 8'hE0, 8'hFC)) &&
                     (in_span(win_b2, 8'h40, 8'h7E) || in_span(win_b2, 8'h80, 8'hFC)))
            begin
                sj_score = add_capped(sj_score, 2);
                sj_skip  = 1'b1;
            end

            if (u8_skip != 2'd0)
                u8_skip = u8_skip - 2'd1;
            else if (in_span(win_b1, 8'hC0, 8'hDF) && in_span(win_b2, 8'h80, 8'hBF))
            begin
                u8_score = add_capped(u8_score, 2);
                u8_skip  = 2'd1;
            end
            else if (in_span(win_b1, 8'hE0, 8'hEF) && in_span(win_b2, 8'h80, 8'hBF) &&
                     in_span(b, 8'h80, 8'hBF))
            begin
                u8_score = add_capped(u8_score, 3);
                u8_skip  = 2'd2;
            end
        end

        win_b1 = win_b2;
        win_b2 = b;
        if (seen_count != POS_LATER)
            seen_count = seen_count + 2'd1;

        if (!is_last)
            return 1'b0;

        marked       = mark_intact && seen_count == POS_LATER;
        v.is_utf8    = marked || (k != POS_FIRST && u8_score > sj_score);
        v.bom_found  = marked;
        v.sjis_score = SCORE_W'(sj_score);
        v.utf8_score = SCORE_W'(u8_score);
        clear_scan_state();
        return 1'b1;
    endfunction

    task automatic add_row(input logic [7:0] value, input bit is_last, input bit typed,
                           input bit is_utf8, input bit bom_found, input int sjis,
                           input int utf8);
        text_row_t r;
        r.value           = value;
        r.is_last         = is_last;
        r.typed           = typed;
        r.want.is_utf8    = is_utf8;
        r.want.bom_found  = bom_found;
        r.want.sjis_score = SCORE_W'(sjis);
        r.want.utf8_score = SCORE_W'(utf8);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic append_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endtask

    // Offer one byte, with a random gap first outside the steady stretch; hold it until the request is taken.
    task automatic send_byte(input logic [7:0] b, input bit is_last, input bit typed,
                             input verdict_t want);
        verdict_t v;
        int       gap;
        gap = 0;
        if (!steady)
            while (gap < 20 && $urandom_range(99) < 26)
                gap++;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (classify_byte(b, is_last, v))
            verdicts_due.insert(verdicts_due.size(), typed ? want : v);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
        if (is_last)
            texts_sent++;
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
    endtask

    task automatic push_utf8_piece();
        int r;
        r = $urandom_range(9);
        if (r < 3)
            append_byte(8'($urandom_range(8'h7F)));
        else if (r < 6)
        begin
            append_byte(8'($urandom_range(8'hDF, 8'hC0)));
            append_byte(8'($urandom_range(8'hBF, 8'h80)));
        end
        else
        begin
            append_byte(8'($urandom_range(8'hEF, 8'hE0)));
            append_byte(8'($urandom_range(8'hBF, 8'h80)));
            append_byte(8'($urandom_range(8'hBF, 8'h80)));
        end
    endtask

    task automatic push_sjis_piece();
        if ($urandom_range(9) < 3)
            append_byte(8'($urandom_range(8'h7F)));
        else
        begin
            if ($urandom_range(1))
                append_byte(8'($urandom_range(8'h9F, 8'h81)));
            else
                append_byte(8'($urandom_range(8'hFC, 8'hE0)));
            if ($urandom_range(1))
                append_byte(8'($urandom_range(8'h7E, 8'h40)));
            else
                append_byte(8'($urandom_range(8'hFC, 8'h80)));
        end
    endtask

    task automatic build_text(input text_style_t style, input int len);
        text_buf.delete();
        if (style == TXT_MARKED)
        begin
            append_byte(BOM_0);
            append_byte(BOM_1);
            // now and then break the mark on its last byte
            append_byte($urandom_range(4) == 0 ? 8'($urandom) : BOM_2);
        end
        while (text_buf.size() < len)
        begin
            case (style)
                TXT_ASCII: append_byte(8'($urandom_range(8'h7F)));
                TXT_SJIS:  push_sjis_piece();
                TXT_NOISE: append_byte(8'($urandom));
                TXT_MIXED:
                begin
                    if ($urandom_range(1))
                        push_utf8_piece();
                    else
                        push_sjis_piece();
                    // corrupt a byte now and then to break sequences
                    if ($urandom_range(3) == 0)
                        text_buf[text_buf.size() - 1] = 8'($urandom);
                end
                default:   push_utf8_piece();
            endcase
        end
        while (text_buf.size() > len)
            void'(text_buf.pop_back());
    endtask

    // sink side: random backpressure and verdict checks
    initial
    begin
        verdict_t got;
        verdict_t want;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = verdict_t'(m_axis_tdata[OUT_W-1:0]);
                if (verdicts_due.size() == 0)
                begin
                    $error("unexpected verdict: is_utf8 %0d bom_found %0d sjis %0d utf8 %0d",
                           got.is_utf8, got.bom_found, got.sjis_score, got.utf8_score);
                    mismatches++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    verdicts_checked++;
                    if (want.is_utf8)
                        utf8_verdicts++;
                    if (want.bom_found)
                        marked_verdicts++;
                    if (got.is_utf8 !== want.is_utf8)
                    begin
                        $error("is_utf8: expected %0d, got %0d", want.is_utf8, got.is_utf8);
                        mismatches++;
                    end
                    if (got.bom_found !== want.bom_found)
                    begin
                        $error("bom_found: expected %0d, got %0d",
                               want.bom_found, got.bom_found);
                        mismatches++;
                    end
                    if (got.sjis_score !== want.sjis_score)
                    begin
                        $error("sjis_score: expected %0d, got %0d",
                               want.sjis_score, got.sjis_score);
                        mismatches++;
                    end
                    if (got.utf8_score !== want.utf8_score)
                    begin
                        $error("utf8_score: expected %0d, got %0d",
                               want.utf8_score, got.utf8_score);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 26);
        end
    end

    // watchdog: end the run when no request moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no request moved for %0d cycles, %0d verdicts outstanding",
                 QUIET_LIMIT, verdicts_due.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int          random_bytes;
        int          r;
        int          len;
        text_style_t style;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        steady        = 1'b0;
        mismatches    = 0;
        clear_scan_state();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte texts at both byte extremes
        add_row(8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 0, 0);
        add_row(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 0, 0);
        // two-byte text: the mark cannot complete, nothing is scanned
        add_row(BOM_0, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(BOM_1, 1'b1, 1'b1, 1'b0, 1'b0, 0, 0);
        // zero bytes are ordinary bytes
        add_row(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 0, 0);
        // byte order mark, scores still reported
        add_row(BOM_0, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(BOM_1, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(BOM_2, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(8'h41, 1'b1, 1'b0, 1'b0, 1'b0, 0, 0);
        // two-byte UTF-8 sequence
        add_row(8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(8'hA9, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(8'h41, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(8'h41, 1'b1, 1'b0, 1'b0, 1'b0, 0, 0);
        // Shift-JIS pairs
        add_row(8'h82, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(8'hA0, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(8'h82, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(8'hA2, 1'b1, 1'b0, 1'b0, 1'b0, 0, 0);
        // three-byte UTF-8 sequence that also reads as a Shift-JIS pair
        add_row(8'hE3, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(8'h81, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(8'h82, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        add_row(8'h7F, 1'b1, 1'b0, 1'b0, 1'b0, 0, 0);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].value, dir_rows[i].is_last, dir_rows[i].typed,
                      dir_rows[i].want);

        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            // hold both sides busy through one stretch
            steady = random_bytes >= 150 && random_bytes < 230;
            r = $urandom_range(99);
            if (r < 25)
                style = TXT_UTF8;
            else if (r < 50)
                style = TXT_SJIS;
            else if (r < 60)
                style = TXT_MARKED;
            else if (r < 75)
                style = TXT_MIXED;
            else if (r < 90)
                style = TXT_NOISE;
            else
                style = TXT_ASCII;
            len = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(24, 3);
            build_text(style, len);
            send_text();
            random_bytes += text_buf.size();
        end
        steady = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d texts, %0d bytes; checked %0d verdicts", texts_sent, bytes_sent,
                 verdicts_checked);
        $display("  %0d judged UTF-8, %0d with byte order mark",
                 utf8_verdicts, marked_verdicts);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/sjut_pkg.sv
sv/sjut_scan.sv
sv/sjis_utf8_text_detector.sv
tb/testbench.sv
